>>> rtl/slms_pkg.sv
// Package with shared types and constants of the separable local maximum suppression block.
`default_nettype none
package slms_pkg;

    localparam int FRAME_BITS  = 11;
    localparam int KERNEL_BITS = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd3;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [KERNEL_BITS-1:0] kh;
        logic [KERNEL_BITS-1:0] kw;
        logic [FRAME_BITS-1:0]  h;
        logic [FRAME_BITS-1:0]  w;
    } cfg_t;

    // One result request: position of the pixel to evaluate
    typedef struct packed {
        logic [FRAME_BITS-1:0] row;
        logic [FRAME_BITS-1:0] col;
        logic                  last;
    } job_t;

    typedef struct packed {
        logic frame_done;
    } back_status_t;

endpackage
`default_nettype wire

>>> rtl/slms_store.sv
// Row store memory: one write port, one registered read port.
`default_nettype none
module slms_store #(
    parameter int SB = 16,
    parameter int AW = 14
) (
    input  wire logic          aclk,
    input  wire logic          wen,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [SB-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [SB-1:0] rdata_reg
);

    logic [SB-1:0] mem [2**AW];

    // Write sample
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    // Read sample, registered
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/slms_queue.sv
// Short request queue between front and back.
`default_nettype none
module slms_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire slms_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output slms_pkg::job_t     pop_job
);

    localparam int D  = slms_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CNTW = $clog2(D + 1);

    slms_pkg::job_t    q_reg [D];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [CNTW-1:0]   cnt_reg;

    assign full      = (cnt_reg == CNTW'(D));
    assign not_empty = (cnt_reg != '0);
    assign pop_job   = q_reg[rp_reg];

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(D - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(D - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/slms_front.sv
// Front part: configuration, sample intake into the row store, request issue.
`default_nettype none
module slms_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_KERNEL  = 15,
    parameter int SB          = 16,
    parameter int SL          = 5,
    parameter int XW          = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wen,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [slms_pkg::FRAME_BITS-1:0] cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_mode,
    input  wire logic signed [15:0]       s_pixel_value,
    output slms_pkg::cfg_t                cfg,
    output logic                          st_wen,
    output logic [SL+XW-1:0]              st_waddr,
    output logic [SB-1:0]                 st_wdata,
    input  wire logic                     q_full,
    output logic                          q_push,
    output slms_pkg::job_t                q_job,
    input  wire slms_pkg::back_status_t   bstat
);

    localparam int FB = slms_pkg::FRAME_BITS;
    localparam int KB = slms_pkg::KERNEL_BITS;

    logic [KB-1:0] kh_reg, kw_reg;
    logic [FB-1:0] fh_reg, fw_reg;
    logic [FB-1:0] in_row_reg, in_col_reg, out_row_reg, out_col_reg;
    logic          hold_reg;

    logic [FB-1:0] in_row_next, in_col_next, out_row_next, out_col_next;
    logic          hold_next;
    logic          accept, due, last, known;
    logic [31:0]   need_row, need_col, row_ext, col_ext;
    logic [47:0]   pix_ext;

    // Clamp configuration
    always_comb begin
        cfg.kh = (kh_reg == '0) ? KB'(1) :
                 (32'(kh_reg) > MAX_KERNEL) ? KB'(MAX_KERNEL) : kh_reg;
        cfg.kw = (kw_reg == '0) ? KB'(1) :
                 (32'(kw_reg) > MAX_KERNEL) ? KB'(MAX_KERNEL) : kw_reg;
        cfg.h  = (fh_reg == '0) ? FB'(1) :
                 (32'(fh_reg) > MAX_HEIGHT) ? FB'(MAX_HEIGHT) : fh_reg;
        cfg.w  = (fw_reg == '0) ? FB'(1) :
                 (32'(fw_reg) > MAX_WIDTH) ? FB'(MAX_WIDTH) : fw_reg;
    end

    assign s_ready = !q_full && !hold_reg;
    assign accept  = s_valid && s_ready;
    assign known   = (cfg_index == slms_pkg::CFG_KERNEL_HEIGHT) ||
                     (cfg_index == slms_pkg::CFG_KERNEL_WIDTH) ||
                     (cfg_index == slms_pkg::CFG_FRAME_HEIGHT) ||
                     (cfg_index == slms_pkg::CFG_FRAME_WIDTH);

    // Store sample at its slot
    assign pix_ext  = {32'd0, s_pixel_value};
    assign st_wdata = pix_ext[SB-1:0];
    assign row_ext  = 32'(in_row_reg);
    assign col_ext  = 32'(in_col_reg);
    assign st_waddr = {row_ext[SL-1:0], col_ext[XW-1:0]};
    assign st_wen   = accept && !s_mode && (in_row_reg < cfg.h);

    // Advance intake, then decide whether a request is due
    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        hold_next    = hold_reg;
        if (bstat.frame_done) begin
            hold_next = 1'b0;
        end
        if (st_wen) begin
            if (in_col_reg + 1'b1 >= cfg.w) begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        need_row = 32'(out_row_reg) + 32'(cfg.kh) - 32'd1 - 32'(cfg.kh >> 1);
        if (need_row > 32'(cfg.h) - 32'd1) begin
            need_row = 32'(cfg.h) - 32'd1;
        end
        need_col = 32'(out_col_reg) + 32'(cfg.kw) - 32'd1 - 32'(cfg.kw >> 1);
        if (need_col > 32'(cfg.w) - 32'd1) begin
            need_col = 32'(cfg.w) - 32'd1;
        end
        due  = (32'(in_row_next) > need_row) ||
               ((32'(in_row_next) == need_row) && (32'(in_col_next) > need_col));
        last = (out_row_reg == cfg.h - 1'b1) && (out_col_reg == cfg.w - 1'b1);
        q_push = accept && due;
        if (q_push) begin
            if (last) begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                hold_next    = 1'b1;
            end else if (out_col_reg + 1'b1 >= cfg.w) begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        if (cfg_wen && known) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
    end

    assign q_job.row  = out_row_reg;
    assign q_job.col  = out_col_reg;
    assign q_job.last = last;

    // Hold configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kh_reg      <= KB'(3);
            kw_reg      <= KB'(3);
            fh_reg      <= FB'(64);
            fw_reg      <= FB'(64);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            hold_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    slms_pkg::CFG_KERNEL_HEIGHT: kh_reg <= cfg_wdata[KB-1:0];
                    slms_pkg::CFG_KERNEL_WIDTH:  kw_reg <= cfg_wdata[KB-1:0];
                    slms_pkg::CFG_FRAME_HEIGHT:  fh_reg <= cfg_wdata;
                    slms_pkg::CFG_FRAME_WIDTH:   fw_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            hold_reg    <= hold_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/slms_back.sv
// Back part: walks the window of one request through the row store and forms the result.
`default_nettype none
module slms_back #(
    parameter int SB = 16,
    parameter int SL = 5,
    parameter int XW = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire slms_pkg::cfg_t         cfg,
    input  wire logic                   q_not_empty,
    input  wire slms_pkg::job_t         q_job,
    output logic                        q_pop,
    output logic [SL+XW-1:0]            st_raddr,
    input  wire logic [SB-1:0]          st_rdata,
    output slms_pkg::back_status_t      bstat,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [14:0]                 m_kept_value,
    output logic                        m_frame_last
);

    localparam int FB = slms_pkg::FRAME_BITS;
    localparam int KB = slms_pkg::KERNEL_BITS;

    typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_t;

    state_t               state_reg;
    slms_pkg::job_t       job_reg;
    logic [KB-1:0]        k_reg, j_reg;
    logic                 p_valid_reg, p_in_reg, p_center_reg, p_first_reg;
    logic                 p_last_reg, p_xin_reg, p_cc_reg;
    logic signed [SB-1:0] m_reg, center_reg, big_reg;
    logic signed [SB:0]   cc_reg;
    logic                 out_valid_reg, out_last_reg;
    logic [14:0]          out_value_reg;

    logic signed [FB+2:0] x, y;
    logic                 x_in, y_in, load;
    logic [31:0]          x_ext, y_ext;
    logic signed [SB-1:0] s, base, m_new, center_new;
    logic [63:0]          big_ext;

    // Window position of the current read
    always_comb begin
        x = $signed({3'b000, job_reg.col}) + $signed({{(FB-KB+3){1'b0}}, k_reg})
            - $signed({{(FB-KB+4){1'b0}}, cfg.kw[KB-1:1]});
        y = $signed({3'b000, job_reg.row}) + $signed({{(FB-KB+3){1'b0}}, j_reg})
            - $signed({{(FB-KB+4){1'b0}}, cfg.kh[KB-1:1]});
        x_in  = (x >= 0) && (x < $signed({3'b000, cfg.w}));
        y_in  = (y >= 0) && (y < $signed({3'b000, cfg.h}));
        x_ext = 32'(x);
        y_ext = 32'(y);
        st_raddr = {y_ext[SL-1:0], x_ext[XW-1:0]};
    end

    // Fold read data into column and row maxima
    always_comb begin
        s          = $signed(st_rdata);
        base       = p_first_reg ? '0 : m_reg;
        m_new      = (p_in_reg && (s > base)) ? s : base;
        center_new = p_center_reg ? s : center_reg;
    end

    assign load    = (state_reg == DONE) && (!out_valid_reg || m_ready);
    assign q_pop   = (state_reg == IDLE) && q_not_empty;
    assign big_ext = 64'(unsigned'(big_reg));
    assign bstat.frame_done = load && job_reg.last;

    assign m_valid      = out_valid_reg;
    assign m_kept_value = out_value_reg;
    assign m_frame_last = out_last_reg;

    // Step the sequencer and hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= (state_reg == RUN);
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (q_not_empty) begin
                        state_reg <= RUN;
                    end
                end
                RUN: begin
                    if ((j_reg == cfg.kh - 1'b1) && (k_reg == cfg.kw - 1'b1)) begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN: begin
                    state_reg <= DONE;
                end
                DONE: begin
                    if (load) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
            k_reg   <= '0;
            j_reg   <= '0;
            big_reg <= '0;
            cc_reg  <= '0;
        end
        if (state_reg == RUN) begin
            if (j_reg == cfg.kh - 1'b1) begin
                j_reg <= '0;
                k_reg <= k_reg + 1'b1;
            end else begin
                j_reg <= j_reg + 1'b1;
            end
        end
        p_in_reg     <= x_in && y_in;
        p_xin_reg    <= x_in;
        p_center_reg <= (j_reg == (cfg.kh >> 1));
        p_first_reg  <= (j_reg == '0);
        p_last_reg   <= (j_reg == cfg.kh - 1'b1);
        p_cc_reg     <= (x == $signed({3'b000, job_reg.col}));
        if (p_valid_reg) begin
            m_reg      <= m_new;
            center_reg <= center_new;
            if (p_last_reg && p_xin_reg) begin
                if (m_new > big_reg) begin
                    big_reg <= m_new;
                end
                if (p_cc_reg) begin
                    cc_reg <= (m_new == center_new) ? (SB+1)'(m_new) : -(SB+1)'(m_new);
                end
            end
        end
        if (load) begin
            out_last_reg  <= job_reg.last;
            out_value_reg <= ((SB+1)'(unsigned'(big_reg)) == cc_reg) ?
                             big_ext[14:0] : 15'd0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/separable_local_max_suppression_top.sv
// Top level of the separable local maximum suppression block.
// Flow: the back part pops the request that makes a result due, walks its window through the
// row store one sample per cycle (RUN), drains the read (DRAIN) and loads the result (DONE).
// It takes the next request only when back in IDLE; requests that cause no
// result are taken one per cycle while the queue has room and no frame end is pending.
// Reset: synchronous, active low; registers return to 3, 3, 64, 64, counters to zero.
`default_nettype none
module separable_local_max_suppression_top #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_KERNEL  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wen,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [slms_pkg::FRAME_BITS-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic signed [15:0]               s_pixel_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [14:0]                           m_kept_value,
    output logic                                  m_frame_last
);

    localparam int SL = $clog2(MAX_KERNEL + slms_pkg::QUEUE_DEPTH + 3);
    localparam int XW = (MAX_WIDTH > 2048) ? slms_pkg::FRAME_BITS :
                        ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1);
    localparam int AW = SL + XW;

    slms_pkg::cfg_t         cfg;
    slms_pkg::job_t         push_job, pop_job;
    slms_pkg::back_status_t bstat;
    logic                   st_wen, q_full, q_push, q_pop, q_not_empty;
    logic [AW-1:0]          st_waddr, st_raddr;
    logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;

    slms_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_KERNEL(MAX_KERNEL),
        .SB(SAMPLE_BITS), .SL(SL), .XW(XW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pixel_value(s_pixel_value), .cfg(cfg),
        .st_wen(st_wen), .st_waddr(st_waddr), .st_wdata(st_wdata),
        .q_full(q_full), .q_push(q_push), .q_job(push_job), .bstat(bstat)
    );

    slms_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_job(push_job), .full(q_full),
        .pop(q_pop), .not_empty(q_not_empty), .pop_job(pop_job)
    );

    slms_store #(.SB(SAMPLE_BITS), .AW(AW)) u_store (
        .aclk(aclk), .wen(st_wen), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata_reg(st_rdata)
    );

    slms_back #(.SB(SAMPLE_BITS), .SL(SL), .XW(XW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_not_empty(q_not_empty), .q_job(pop_job), .q_pop(q_pop),
        .st_raddr(st_raddr), .st_rdata(st_rdata), .bstat(bstat),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kept_value(m_kept_value), .m_frame_last(m_frame_last)
    );

endmodule
`default_nettype wire

>>> sim/separable_local_max_suppression_top_test.sv
// Self-checking testbench for the separable local maximum suppression block.
`timescale 1ns / 100ps
`default_nettype none
module separable_local_max_suppression_top_test;

    localparam int MAX_W  = 1024;
    localparam int MAX_H  = 1024;
    localparam int MAX_K  = 15;
    localparam int KEPT_ROWS = MAX_K + 1;
    localparam bit MODE_SAMPLE = 1'b0;
    localparam bit MODE_DRAIN  = 1'b1;

    typedef struct {
        bit                 mode;
        logic signed [15:0] pix;
    } pixel_req_t;

    typedef struct {
        logic [14:0] kept;
        logic        last;
    } kept_pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [slms_pkg::FRAME_BITS-1:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic signed [15:0] s_pixel_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [14:0] m_kept_value;
    logic        m_frame_last;

    separable_local_max_suppression_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pixel_value(s_pixel_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kept_value(m_kept_value), .m_frame_last(m_frame_last)
    );

    always #5 aclk = ~aclk;

    // Scoreboard state
    pixel_req_t  pending_pixels[$];
    kept_pixel_t kept_queue[$];
    int          error_count = 0;
    int          idle_pct = 0;
    int          items_sent = 0;

    // Mirror of the block state
    int unsigned reg_kh = 3, reg_kw = 3, reg_fh = 64, reg_fw = 64;
    logic [15:0] sample_store [KEPT_ROWS*MAX_W];
    int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint stored_sample(int unsigned row, int unsigned col);
        return longint'($signed(sample_store[(row % KEPT_ROWS)*MAX_W + (col % MAX_W)]));
    endfunction

    // Vertical pass: max of the column window, negated unless the pixel is the max
    function automatic longint column_peak(int unsigned r, int unsigned x,
                                           int unsigned kh, int unsigned h);
        longint m, center, s;
        int y;
        m = 0;
        center = stored_sample(r, x);
        for (int k = 0; k < kh; k++) begin
            y = int'(r) + k - int'(kh / 2);
            if (y < 0 || y >= int'(h)) continue;
            s = stored_sample(y, x);
            if (s > m) m = s;
        end
        return (m == center) ? m : -m;
    endfunction

    task automatic apply_reg(int unsigned idx, int unsigned val);
        case (idx)
            slms_pkg::CFG_KERNEL_HEIGHT: reg_kh = val & 4'hF;
            slms_pkg::CFG_KERNEL_WIDTH:  reg_kw = val & 4'hF;
            slms_pkg::CFG_FRAME_HEIGHT:  reg_fh = val & 11'h7FF;
            slms_pkg::CFG_FRAME_WIDTH:   reg_fw = val & 11'h7FF;
            default: return;
        endcase
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endtask

    // Advance the mirror by one accepted request and queue any kept pixel
    task automatic predict_suppression(bit mode, logic signed [15:0] pix);
        int unsigned kh, kw, h, w, need_row, need_col;
        longint big, center, v, a;
        int x;
        bit last;
        kept_pixel_t res;
        kh = clamp_reg(reg_kh, MAX_K);
        kw = clamp_reg(reg_kw, MAX_K);
        h  = clamp_reg(reg_fh, MAX_H);
        w  = clamp_reg(reg_fw, MAX_W);
        if (mode == MODE_SAMPLE && in_row < h) begin
            sample_store[(in_row % KEPT_ROWS)*MAX_W + (in_col % MAX_W)] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        need_row = out_row + (kh - 1 - kh / 2);
        if (need_row > h - 1) need_row = h - 1;
        need_col = out_col + (kw - 1 - kw / 2);
        if (need_col > w - 1) need_col = w - 1;
        if (!(in_row > need_row || (in_row == need_row && in_col > need_col))) return;
        big = 0;
        center = 0;
        for (int k = 0; k < kw; k++) begin
            x = int'(out_col) + k - int'(kw / 2);
            if (x < 0 || x >= int'(w)) continue;
            v = column_peak(out_row, x, kh, h);
            if (x == int'(out_col)) center = v;
            a = (v < 0) ? -v : v;
            if (a > big) big = a;
        end
        last = (out_row == h - 1) && (out_col == w - 1);
        res.kept = (big == center) ? big[14:0] : '0;
        res.last = last;
        kept_queue.push_back(res);
        if (last) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: present queued requests, idle in bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        pixel_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready) predict_suppression(s_mode, s_pixel_value);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                req = pending_pixels.pop_front();
                s_mode <= req.mode;
                s_pixel_value <= req.pix;
                s_valid <= 1'b1;
                if ($urandom_range(99) < idle_pct) send_gap = $urandom_range(1, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall in bursts, check each kept pixel against the oldest prediction
    int recv_stall = 0;
    always @(posedge aclk) begin
        kept_pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (kept_queue.size() == 0) begin
                    report_mismatch("unexpected result", m_kept_value, -1);
                end else begin
                    want = kept_queue.pop_front();
                    if (m_kept_value !== want.kept)
                        report_mismatch("kept_value", m_kept_value, want.kept);
                    if (m_frame_last !== want.last)
                        report_mismatch("frame_last", m_frame_last, want.last);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                recv_stall = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(int unsigned idx, int unsigned val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_wdata <= val[slms_pkg::FRAME_BITS-1:0];
        apply_reg(idx, val);
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic push_pixel(bit mode, logic signed [15:0] pix);
        pixel_req_t req;
        req.mode = mode;
        req.pix = pix;
        pending_pixels.push_back(req);
        items_sent++;
    endtask

    function automatic logic signed [15:0] rand_score();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            2: return -$signed({13'd0, 3'($urandom_range(0, 3))});
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    // Hold until the block has returned every predicted result; sample after the edge settles
    task automatic wait_quiet();
        while (pending_pixels.size() > 0 || s_valid || kept_queue.size() > 0)
            @(negedge aclk);
        repeat (clamp_reg(reg_kh, MAX_K) * clamp_reg(reg_kw, MAX_K) + 20) @(posedge aclk);
    endtask

    // One frame: samples in raster order with some noise, then drain ticks
    task automatic push_frame(bit noisy);
        int unsigned n;
        n = clamp_reg(reg_fh, MAX_H) * clamp_reg(reg_fw, MAX_W);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(9) == 0) push_pixel(MODE_DRAIN, 16'($urandom));
            push_pixel(MODE_SAMPLE, rand_score());
        end
        for (int i = 0; i < n; i++)
            push_pixel((noisy && $urandom_range(7) == 0) ? MODE_SAMPLE : MODE_DRAIN,
                       16'($urandom));
    endtask

    initial begin
        for (int i = 0; i < KEPT_ROWS*MAX_W; i++) sample_store[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of the samples, early drains, unused config indices, drains after frame end
        write_reg(slms_pkg::CFG_FRAME_HEIGHT, 4);
        write_reg(slms_pkg::CFG_FRAME_WIDTH, 5);
        write_reg(4, 2047);
        write_reg(7, 0);
        push_pixel(MODE_DRAIN, 16'sh7FFF);
        push_pixel(MODE_SAMPLE, 16'sh7FFF);
        push_pixel(MODE_SAMPLE, -16'sd32768);
        push_pixel(MODE_SAMPLE, 16'sd0);
        push_pixel(MODE_SAMPLE, -16'sd1);
        push_pixel(MODE_SAMPLE, 16'sd1);
        push_pixel(MODE_DRAIN, 16'sd0);
        for (int i = 0; i < 14; i++) push_pixel(MODE_SAMPLE, (i % 3 == 0) ? 16'sd5 : 16'sd256);
        push_pixel(MODE_SAMPLE, 16'sh5555);
        for (int i = 0; i < 12; i++) push_pixel(MODE_DRAIN, 16'shAAAA);
        wait_quiet();

        // Zero kernel height and frame height, oversize width, widest kernel row
        write_reg(slms_pkg::CFG_KERNEL_HEIGHT, 0);
        write_reg(slms_pkg::CFG_KERNEL_WIDTH, 15);
        write_reg(slms_pkg::CFG_FRAME_HEIGHT, 0);
        write_reg(slms_pkg::CFG_FRAME_WIDTH, 2047);
        for (int i = 0; i < 14; i++) push_pixel(MODE_SAMPLE, rand_score());
        wait_quiet();

        // Tallest kernel, zero kernel width, oversize height, narrow frame
        write_reg(slms_pkg::CFG_KERNEL_HEIGHT, 15);
        write_reg(slms_pkg::CFG_KERNEL_WIDTH, 0);
        write_reg(slms_pkg::CFG_FRAME_HEIGHT, 2047);
        write_reg(slms_pkg::CFG_FRAME_WIDTH, 0);
        for (int i = 0; i < 12; i++) push_pixel(MODE_SAMPLE, rand_score());
        wait_quiet();

        // Random settings, small frames; the tail runs without idling
        while (items_sent < 1100) begin
            idle_pct = (items_sent > 900) ? 0 : $urandom_range(0, 3) * 10;
            write_reg(slms_pkg::CFG_KERNEL_HEIGHT, $urandom_range(0, 15));
            write_reg(slms_pkg::CFG_KERNEL_WIDTH, $urandom_range(0, 15));
            write_reg(slms_pkg::CFG_FRAME_HEIGHT,
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8));
            write_reg(slms_pkg::CFG_FRAME_WIDTH,
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8));
            if ($urandom_range(4) == 0) write_reg($urandom_range(4, 7), $urandom);
            repeat ($urandom_range(1, 2)) push_frame($urandom_range(3) == 0);
            wait_quiet();
        end

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/slms_pkg.sv
rtl/slms_store.sv
rtl/slms_queue.sv
rtl/slms_front.sv
rtl/slms_back.sv
rtl/separable_local_max_suppression_top.sv
sim/separable_local_max_suppression_top_test.sv
